// File: sv/assert_macros.svh
// assertion macros included by the rtl top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/dq_pkg.sv
// types and codes of the double-ended queue
package dq_pkg;

  localparam logic [1:0] MODE_PUSH_BACK  = 2'd0;
  localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
  localparam logic [1:0] MODE_POP_BACK   = 2'd2;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] popped;
    logic [1:0]         status;
    logic               is_empty;
    logic               is_full;
    logic [4:0]         occupancy;
  } result_t;

endpackage

// File: sv/double_ended_queue_top.sv
// double-ended queue of words in a circular single-port-write memory
//
// usage
//   command channel: item (mode, value) is transferred at a rising edge where
//   start is high and busy is low. busy stays low outside reset, so a new
//   command may be issued every cycle.
//   result channel: one result per command, shown for exactly one cycle with
//   done high, in the cycle after the command transfer. the receiver has no way
//   to stall; it must sample the result in that cycle.
//   throughput: 1 command per cycle. pointer and count updates happen at the
//   command transfer; a pop issues its memory read in that same cycle and the
//   registered read data forms the popped word in the result cycle.
//   a push writes the memory at the command transfer; a pop only reads entries
//   written at earlier edges, so no forwarding is needed.
//   pop of an empty queue gives underflow status and popped zero; push on a
//   full queue gives overflow status and drops the word.
//   reset: synchronous, active high. clears front index, count and the result
//   strobe. memory contents are left as they are; only written entries are
//   ever read back.
`include "assert_macros.svh"

module double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  dq_pkg::item_t   item,
  output logic            done,
  output dq_pkg::result_t result
);
  import dq_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // storage
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  // control state
  logic [IDX_W-1:0] front, front_next;
  logic [CNT_W-1:0] count, count_next;

  // result registers
  logic             pop_pending;
  logic [1:0]       status_q;
  logic             empty_q;
  logic             full_q;
  logic [4:0]       occ_q;

  // command decode
  logic             accept;
  logic             is_push;
  logic             empty_now;
  logic             full_now;
  logic [1:0]       status_next;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [63:0]      val_ext;
  logic [63:0]      pop_ext;

  // wrapped positions
  logic [SUM_W-1:0] back_sum;
  logic [SUM_W-1:0] last_sum;
  logic [IDX_W-1:0] back_pos;
  logic [IDX_W-1:0] last_pos;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_push   = (item.mode == MODE_PUSH_BACK) || (item.mode == MODE_PUSH_FRONT);
  assign empty_now = (count == '0);
  assign full_now  = (count == CNT_W'(DEPTH));

  // slot after the back entry, and the back entry itself
  assign back_sum = SUM_W'(front) + SUM_W'(count);
  assign last_sum = back_sum - SUM_W'(1);
  assign back_pos = (back_sum >= SUM_W'(DEPTH)) ? IDX_W'(back_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(back_sum);
  assign last_pos = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                 : IDX_W'(last_sum);
  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
  assign front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + IDX_W'(1);

  // low word bits go into storage
  assign val_ext = {32'd0, item.value};
  assign wr_data = val_ext[DATA_WIDTH-1:0];

  always_comb begin
    front_next  = front;
    count_next  = count;
    status_next = STATUS_OK;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = back_pos;
    rd_addr     = front;
    if (accept) begin
      unique case (item.mode)
        MODE_PUSH_BACK: begin
          if (full_now) begin
            status_next = STATUS_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = back_pos;
            count_next = count + CNT_W'(1);
          end
        end
        MODE_PUSH_FRONT: begin
          if (full_now) begin
            status_next = STATUS_OVERFLOW;
          end else begin
            wr_en      = 1'b1;
            wr_addr    = front_dec;
            front_next = front_dec;
            count_next = count + CNT_W'(1);
          end
        end
        MODE_POP_BACK: begin
          if (empty_now) begin
            status_next = STATUS_UNDERFLOW;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = last_pos;
            count_next = count - CNT_W'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (empty_now) begin
            status_next = STATUS_UNDERFLOW;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = front;
            front_next = front_inc;
            count_next = count - CNT_W'(1);
          end
        end
        default: begin
          status_next = STATUS_OK;
        end
      endcase
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      front       <= '0;
      count       <= '0;
      done        <= 1'b0;
      pop_pending <= 1'b0;
    end else begin
      front       <= front_next;
      count       <= count_next;
      done        <= accept;
      pop_pending <= rd_en;
    end
  end

  // result fields, taken at the command transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
      empty_q  <= (count_next == '0);
      full_q   <= (count_next == CNT_W'(DEPTH));
      occ_q    <= 5'(count_next);
    end
  end

  assign pop_ext = 64'(rd_data);

  always_comb begin
    result.popped    = pop_pending ? pop_ext[31:0] : 32'sd0;
    result.status    = status_q;
    result.is_empty  = empty_q;
    result.is_full   = full_q;
    result.occupancy = occ_q;
  end

  // checks
  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `ASSERT_NEXT(a_result_follows, clk, rst, accept, done)
  `ASSERT_NEXT(a_idle_holds, clk, rst, !accept, $stable(count) && $stable(front))
  `ASSERT_NEXT(a_push_grows, clk, rst, accept && is_push && !full_now,
               count == $past(count) + CNT_W'(1))
  `ASSERT_ALWAYS(a_rw_exclusive, clk, rst, !(wr_en && rd_en))

endmodule
